// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the span finder RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication checked while the block is out of reset.
`define FBDSF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Next-cycle check that applies after the condition has been sampled.
`define FBDSF_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ===== hdl/fbdsf_pkg.sv =====
// Package for the framebuffer span finder: payload types, queue entry type and sizes.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package fbdsf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int CFG_W   = 11;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int WCOL_W  = COL_W - 2;
  localparam int WORDS_W = WCOL_W + 1;
  localparam int LANES   = 4;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  typedef enum logic {
    REG_ROW_WIDTH    = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [31:0] new_word;
    logic [31:0] old_word;
  } in_item_t;

  typedef struct packed {
    logic [9:0] span_row;
    logic [9:0] first_pixel;
    logic [9:0] last_pixel;
  } out_item_t;

  typedef struct packed {
    logic             has_diff;
    logic             row_end;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] first_col;
    logic [COL_W-1:0] last_col;
  } entry_t;

endpackage

`default_nettype wire

// ===== hdl/fbdsf_front.sv =====
// Front part of the span finder: accepts word pairs, masks and compares lanes,
// tracks the raster position and classifies each word. Depends on fbdsf_pkg.
`default_nettype none

module fbdsf_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [fbdsf_pkg::CFG_W-1:0]     row_width_i,
  input  logic [fbdsf_pkg::CFG_W-1:0]     frame_height_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  fbdsf_pkg::in_item_t             in_item_i,
  input  logic                            q_full_i,
  output logic                            push_o,
  output fbdsf_pkg::entry_t               entry_o
);
  import fbdsf_pkg::*;

  `include "assert_macros.svh"

  logic [WCOL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;

  logic [CFG_W-1:0]   width;
  logic [CFG_W-1:0]   height;
  logic [CFG_W-1:0]   width_p3;
  logic [WORDS_W-1:0] words;
  logic [WORDS_W-1:0] col_p1;
  logic [ROW_W:0]     row_p1;
  logic               last_word;
  logic [LANES-1:0]   mask;
  logic [1:0]         lo;
  logic [1:0]         hi;
  logic               accept;

  always_comb begin
    if (row_width_i == '0) begin
      width = CFG_W'(1);
    end else if (row_width_i > CFG_W'(MAX_WIDTH)) begin
      width = CFG_W'(MAX_WIDTH);
    end else begin
      width = row_width_i;
    end
    if (frame_height_i == '0) begin
      height = CFG_W'(1);
    end else if (frame_height_i > CFG_W'(MAX_HEIGHT)) begin
      height = CFG_W'(MAX_HEIGHT);
    end else begin
      height = frame_height_i;
    end
  end

  assign width_p3  = width + CFG_W'(3);
  assign words     = width_p3[CFG_W-1:2];
  assign col_p1    = {1'b0, col_q} + WORDS_W'(1);
  assign last_word = (col_p1 >= words);
  assign row_p1    = {1'b0, row_q} + (ROW_W+1)'(1);

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      mask[l] = ({1'b0, col_q, 2'(l)} < width) &&
                (in_item_i.new_word[8*l +: 8] != in_item_i.old_word[8*l +: 8]);
    end
    lo = 2'd0;
    for (int l = LANES - 1; l >= 0; l--) begin
      if (mask[l]) begin
        lo = 2'(l);
      end
    end
    hi = 2'd3;
    for (int l = 0; l < LANES; l++) begin
      if (mask[l]) begin
        hi = 2'(l);
      end
    end
  end

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept;

  always_comb begin
    entry_o.has_diff  = (mask != '0);
    entry_o.row_end   = last_word;
    entry_o.row       = row_q;
    entry_o.first_col = {col_q, lo};
    entry_o.last_col  = {col_q, hi};
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_word) begin
        col_d = '0;
        if (row_p1 >= (ROW_W+1)'(height)) begin
          row_d = '0;
        end else begin
          row_d = row_p1[ROW_W-1:0];
        end
      end else begin
        col_d = col_p1[WCOL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  `FBDSF_ASSERT_NEXT(a_row_end_wraps_col, accept && last_word, col_q == '0,
                     "column did not return to zero after the last word of a row")
  `FBDSF_ASSERT(a_no_push_when_full, q_full_i |-> !push_o,
                "transaction pushed into a full queue")

endmodule

`default_nettype wire

// ===== hdl/fbdsf_queue.sv =====
// Short queue between the front and back parts of the span finder.
// Holds classified words; depends on fbdsf_pkg.
`default_nettype none

module fbdsf_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  fbdsf_pkg::entry_t entry_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              pop_i,
  output fbdsf_pkg::entry_t head_o
);
  import fbdsf_pkg::*;

  `include "assert_macros.svh"

  entry_t mem_q [Q_DEPTH];

  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_PTR_W:0]   count_q, count_d;
  logic               do_pop;

  assign full_o  = (count_q == (Q_PTR_W+1)'(Q_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + Q_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + Q_PTR_W'(1);
    end
    if (push_i && !do_pop) begin
      count_d = count_q + (Q_PTR_W+1)'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - (Q_PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `FBDSF_ASSERT(a_count_bound, count_q <= (Q_PTR_W+1)'(Q_DEPTH),
                "queue count exceeds its depth")
  `FBDSF_ASSERT(a_ptr_gap, (wr_ptr_q - rd_ptr_q) == count_q[Q_PTR_W-1:0],
                "queue pointers disagree with the count")

endmodule

`default_nettype wire

// ===== hdl/fbdsf_back.sv =====
// Back part of the span finder: merges classified words into spans and holds
// the finished span in the output register. Depends on fbdsf_pkg.
`default_nettype none

module fbdsf_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  fbdsf_pkg::entry_t    head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output fbdsf_pkg::out_item_t out_item_o
);
  import fbdsf_pkg::*;

  `include "assert_macros.svh"

  logic             open_q, open_d;
  logic [COL_W-1:0] first_q, first_d;
  logic [COL_W-1:0] last_q, last_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  logic pop;
  logic emit;

  assign pop   = q_valid_i && !(out_valid_q && out_stall_i);
  assign pop_o = pop;

  always_comb begin
    open_d      = open_q;
    first_d     = first_q;
    last_d      = last_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    emit        = 1'b0;
    if (pop) begin
      if (head_i.has_diff) begin
        if (!open_q) begin
          first_d = head_i.first_col;
        end
        last_d = head_i.last_col;
        open_d = !head_i.row_end;
        emit   = head_i.row_end;
      end else begin
        open_d = 1'b0;
        emit   = open_q;
      end
      if (emit) begin
        out_d.span_row    = 10'(head_i.row);
        out_d.first_pixel = 10'(first_d);
        out_d.last_pixel  = 10'(last_d);
        out_valid_d       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    last_q  <= last_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      open_q      <= open_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `FBDSF_ASSERT_NEXT(a_row_end_closes, pop && head_i.row_end, !open_q,
                     "span still open after the end of a row")
  `FBDSF_ASSERT_NEXT(a_emit_loads_out, pop && emit, out_valid_q,
                     "finished span was not presented")
  `FBDSF_ASSERT(a_span_order, out_valid_q |-> (out_q.first_pixel <= out_q.last_pixel),
                "span ends before it starts")

endmodule

`default_nettype wire

// ===== hdl/framebuffer_diff_span_finder.sv =====
// Top level of the framebuffer span finder: configuration registers, front,
// queue and back. Depends on fbdsf_pkg, fbdsf_front, fbdsf_queue and fbdsf_back.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------
//   input    | in_valid_i / in_stall_o | in_item_i  (new_word, old_word)
//   output   | out_valid_o / out_stall_i | out_item_o (row, first, last)
//   config   | psel, penable, pwrite   | paddr, pwdata, prdata
//
// One word pair is accepted every cycle while the four-entry queue has room.
// A span appears in the output register the cycle after the back part takes
// the word that closes it. The input stalls only when the queue is full, which
// happens only after the output side has stalled.
// Reset clears the raster position, the open span and all valid flags;
// the width and height registers reset to 128.
`default_nettype none

module framebuffer_diff_span_finder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  fbdsf_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output fbdsf_pkg::out_item_t out_item_o
);
  import fbdsf_pkg::*;

  logic [CFG_W-1:0] row_width_q, row_width_d;
  logic [CFG_W-1:0] frame_height_q, frame_height_d;
  reg_idx_e         reg_idx;
  logic             cfg_wr;

  logic   q_full;
  logic   q_valid;
  logic   push;
  logic   pop;
  entry_t entry;
  entry_t head;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    row_width_d    = row_width_q;
    frame_height_d = frame_height_q;
    prdata         = '0;
    case (reg_idx)
      REG_ROW_WIDTH: begin
        prdata = 32'(row_width_q);
        if (cfg_wr) begin
          row_width_d = pwdata[CFG_W-1:0];
        end
      end
      REG_FRAME_HEIGHT: begin
        prdata = 32'(frame_height_q);
        if (cfg_wr) begin
          frame_height_d = pwdata[CFG_W-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q    <= CFG_W'(128);
      frame_height_q <= CFG_W'(128);
    end else begin
      row_width_q    <= row_width_d;
      frame_height_q <= frame_height_d;
    end
  end

  fbdsf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .row_width_i    (row_width_q),
    .frame_height_i (frame_height_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_item_i      (in_item_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .entry_o        (entry)
  );

  fbdsf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .head_o  (head)
  );

  fbdsf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ===== tb/framebuffer_diff_span_finder_test.sv =====
// Self-checking testbench for framebuffer_diff_span_finder: word pairs are streamed in under
// random bursts and stalls, spans are predicted in step and checked as they leave the block.
// Depends on fbdsf_pkg and the framebuffer_diff_span_finder RTL.
module framebuffer_diff_span_finder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fbdsf_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 20;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_item_t    in_item_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_item_o;

  framebuffer_diff_span_finder u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always #5 clk_i = ~clk_i;

  in_item_t    pending_words[$];
  out_item_t   expected_spans[$];
  int          words_sent   = 0;
  int          words_taken  = 0;
  int          error_count  = 0;
  int          cycle_count  = 0;
  int          burst_left   = 1;
  int          gap_left     = 0;
  int          hold_left    = 0;
  int          holds_done   = 0;
  int          mode_left    = 0;
  stall_mode_e stall_mode   = STALL_NONE;

  logic [10:0] cfg_row_width    = 11'd128;
  logic [10:0] cfg_frame_height = 11'd128;
  logic [7:0]  word_column      = '0;
  logic [9:0]  row_counter      = '0;
  logic [9:0]  run_first        = '0;
  logic [9:0]  run_last         = '0;
  bit          run_open         = 1'b0;

  function automatic void predict_span(input in_item_t pair);
    int unsigned width, height, words, base, lo, hi, lane;
    logic [3:0]  diff;
    out_item_t   span;
    bit          emit;
    width  = (cfg_row_width == 0) ? 1 :
             (cfg_row_width > MAX_WIDTH) ? MAX_WIDTH : cfg_row_width;
    height = (cfg_frame_height == 0) ? 1 :
             (cfg_frame_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_frame_height;
    words  = (width + 3) >> 2;
    base   = int'(word_column) << 2;
    diff   = '0;
    emit   = 1'b0;
    span   = '0;
    for (lane = 0; lane < LANES; lane++) begin
      if (base + lane < width && pair.new_word[8*lane +: 8] != pair.old_word[8*lane +: 8]) begin
        diff[lane] = 1'b1;
      end
    end
    if (diff != 0) begin
      lo = 0;
      while (!diff[lo]) lo++;
      hi = 3;
      while (!diff[hi]) hi--;
      if (!run_open) begin
        run_first = 10'(base + lo);
        run_open  = 1'b1;
      end
      run_last = 10'(base + hi);
    end else if (run_open) begin
      span     = '{row_counter, run_first, run_last};
      emit     = 1'b1;
      run_open = 1'b0;
    end
    if (int'(word_column) + 1 >= words) begin
      if (run_open) begin
        span     = '{row_counter, run_first, run_last};
        emit     = 1'b1;
        run_open = 1'b0;
      end
      word_column = '0;
      if (int'(row_counter) + 1 >= height) row_counter = '0;
      else row_counter = row_counter + 10'd1;
    end else begin
      word_column = word_column + 8'd1;
    end
    if (emit) expected_spans.push_back(span);
  endfunction

  function automatic in_item_t make_pair(input bit differ);
    in_item_t   pair;
    logic [3:0] lanes;
    int         i;
    pair.old_word = $urandom;
    pair.new_word = pair.old_word;
    if (differ) begin
      lanes = 4'($urandom_range(1, 15));
      for (i = 0; i < LANES; i++) begin
        if (lanes[i]) begin
          pair.new_word[8*i +: 8] = pair.old_word[8*i +: 8] ^ 8'($urandom_range(1, 255));
        end
      end
    end
    return pair;
  endfunction

  task automatic queue_pair(input logic [31:0] new_word, input logic [31:0] old_word);
    pending_words.push_back(in_item_t'({new_word, old_word}));
  endtask

  task automatic queue_random_words(input int count);
    bit in_run;
    int k;
    in_run = 1'b0;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 3) == 0) in_run = !in_run;
      if ($urandom_range(0, 9) == 0) begin
        queue_pair($urandom, $urandom);
      end else begin
        pending_words.push_back(make_pair(in_run));
      end
    end
  endtask

  task automatic settle();
    while (pending_words.size() != 0 || words_sent != words_taken ||
           expected_spans.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [10:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_ROW_WIDTH) cfg_row_width = value;
    else cfg_frame_height = value;
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && words_sent == words_taken) begin
      if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left--;
      end else if (pending_words.size() != 0) begin
        in_item_i  <= pending_words.pop_front();
        in_valid_i <= 1'b1;
        words_sent++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (holds_done < 2 && words_taken >= 150 + 250 * holds_done) begin
      hold_left = $urandom_range(50, 80);
      holds_done++;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(20, 80);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_NONE:  out_stall_i <= 1'b0;
        STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
        default:     out_stall_i <= (mode_left % 4 == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_spans.size() == 0) begin
          $display("%0t: span with none expected: row %0d first %0d last %0d", $time,
                   out_item_o.span_row, out_item_o.first_pixel, out_item_o.last_pixel);
          error_count++;
        end else begin
          want = expected_spans.pop_front();
          if (out_item_o.span_row != want.span_row ||
              out_item_o.first_pixel != want.first_pixel ||
              out_item_o.last_pixel != want.last_pixel) begin
            $display({"%0t: span mismatch, expected row %0d first %0d last %0d, ",
                      "got row %0d first %0d last %0d"},
                     $time, want.span_row, want.first_pixel, want.last_pixel,
                     out_item_o.span_row, out_item_o.first_pixel, out_item_o.last_pixel);
            error_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        predict_span(in_item_i);
        words_taken++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("framebuffer_diff_span_finder_test: FAIL");
      $finish;
    end
  end

  initial begin
    int p, width, height, count;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    queue_pair(32'h0000_0000, 32'h0000_0000);
    queue_pair(32'hFFFF_FFFF, 32'h0000_0000);
    queue_pair(32'h0000_0000, 32'hFFFF_FFFF);
    queue_pair(32'hAAAA_AAAA, 32'hAAAA_AAAA);
    queue_pair(32'h0000_0001, 32'h0000_0000);
    queue_pair(32'h8000_0000, 32'h0000_0000);
    queue_pair(32'h5555_5555, 32'h5555_5555);
    queue_pair(32'h00FF_FF00, 32'h0000_0000);
    queue_pair(32'h1234_5678, 32'h1234_5678);
    settle();

    write_reg(REG_ROW_WIDTH, 11'd8);
    write_reg(REG_FRAME_HEIGHT, 11'd0);
    queue_pair(32'h00FF_0000, 32'h0000_0000);
    queue_pair(32'hFFFF_FFFF, 32'h0000_0000);
    queue_pair(32'h0000_FF00, 32'h0000_0000);
    queue_pair(32'h1234_5678, 32'h1234_5678);
    queue_pair(32'h0000_00FF, 32'h0000_0000);
    settle();

    write_reg(REG_ROW_WIDTH, 11'd5);
    write_reg(REG_FRAME_HEIGHT, 11'd2);
    queue_pair(32'hC3C3_C3C3, 32'hC3C3_C3C3);
    queue_pair(32'hFFFF_FF00, 32'h0000_0000);
    queue_pair(32'hFF00_0000, 32'h0000_0000);
    queue_pair(32'h0000_00FF, 32'h0000_0000);
    settle();

    write_reg(REG_ROW_WIDTH, 11'd0);
    write_reg(REG_FRAME_HEIGHT, 11'd2047);
    queue_pair(32'h0000_FF00, 32'h0000_0000);
    queue_pair(32'h0000_00FF, 32'h0000_0000);
    queue_pair(32'h0000_0000, 32'h0000_00FF);
    settle();

    for (p = 0; p < 7; p++) begin
      case (p)
        0:       begin width = 37;   height = 3;    count = 80;  end
        1:       begin width = 1024; height = 2;    count = 200; end
        2:       begin width = 13;   height = 4;    count = 60;  end
        3:       begin width = 1;    height = 1024; count = 60;  end
        4:       begin width = 2047; height = 1;    count = 40;  end
        default: begin
          width  = $urandom_range(1, 200);
          height = $urandom_range(1, 6);
          count  = 45;
        end
      endcase
      write_reg(REG_ROW_WIDTH, 11'(width));
      write_reg(REG_FRAME_HEIGHT, 11'(height));
      queue_random_words(count);
      settle();
    end

    if (error_count == 0) begin
      $display("framebuffer_diff_span_finder_test: PASS");
    end else begin
      $display("framebuffer_diff_span_finder_test: FAIL");
    end
    $finish;
  end

endmodule
